[hw/rtl/gpsp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gpsp_pkg
// Shared types and constants of the game pad serial port unit.
// ---------------------------------------------------------------------------
package gpsp_pkg;

  localparam int unsigned NumPads    = 4;
  localparam int unsigned BtnW       = 10;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned MainW      = 20;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned RdataW     = 3;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned PhaseW     = 3;

  // Commands
  localparam logic [CmdW-1:0] CmdFrame = 2'd0;
  localparam logic [CmdW-1:0] CmdVsync = 2'd1;
  localparam logic [CmdW-1:0] CmdWrite = 2'd2;
  localparam logic [CmdW-1:0] CmdRead  = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgArcadeMode  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSwapType    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFourPlayer  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgTurboSpeeds = 2'd3;

  // Arcade swap modes
  localparam logic [2:0] SwapNone       = 3'd0;
  localparam logic [2:0] SwapPads       = 3'd1;
  localparam logic [2:0] SwapMergeOwn   = 3'd2;
  localparam logic [2:0] SwapMergeCross = 3'd3;
  localparam logic [2:0] SwapNoneForce  = 3'd4;
  localparam logic [2:0] SwapPadsForce  = 3'd5;
  localparam logic [2:0] SwapSelect     = 3'd6;

  localparam logic [ByteW-1:0] PadMask     = 8'hF3;
  localparam logic [ByteW-1:0] CoinBit     = 8'h08;
  localparam logic [MainW-1:0] SigPort0    = 20'h80000;
  localparam logic [MainW-1:0] SigPort1    = 20'h40000;

  // Turbo pattern length and on-time per speed code
  localparam logic [3:0][PhaseW-1:0] SpeedLen = {3'd2, 3'd3, 3'd4, 3'd6};
  localparam logic [3:0][PhaseW-1:0] SpeedOn  = {3'd1, 3'd2, 3'd2, 3'd3};

  typedef logic [NumPads-1:0][ByteW-1:0] pad_bytes_t;

  typedef struct packed {
    logic                  arcade_mode;
    logic [2:0]            swap_type;
    logic                  four_player;
    logic [CfgDataW-1:0]   turbo_speeds;
  } cfg_t;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic            port_sel;
    logic            strobe_bit;
    logic [BtnW-1:0] buttons_pad1;
    logic [BtnW-1:0] buttons_pad2;
    logic [BtnW-1:0] buttons_pad3;
    logic [BtnW-1:0] buttons_pad4;
    logic            mic_button;
  } in_item_t;

endpackage

[hw/rtl/gpsp_in_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gpsp_in_if
// Valid/ready channel carrying one command transaction.
// ---------------------------------------------------------------------------
interface gpsp_in_if;
  import gpsp_pkg::*;

  logic            valid;
  logic            ready;
  logic [CmdW-1:0] cmd;
  logic            port_sel;
  logic            strobe_bit;
  logic [BtnW-1:0] buttons_pad1;
  logic [BtnW-1:0] buttons_pad2;
  logic [BtnW-1:0] buttons_pad3;
  logic [BtnW-1:0] buttons_pad4;
  logic            mic_button;

  modport source (
    output valid, cmd, port_sel, strobe_bit, buttons_pad1, buttons_pad2,
           buttons_pad3, buttons_pad4, mic_button,
    input  ready
  );
  modport sink (
    input  valid, cmd, port_sel, strobe_bit, buttons_pad1, buttons_pad2,
           buttons_pad3, buttons_pad4, mic_button,
    output ready
  );
endinterface

[hw/rtl/gpsp_out_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gpsp_out_if
// Valid/ready channel carrying one read-data transaction.
// ---------------------------------------------------------------------------
interface gpsp_out_if;
  import gpsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [RdataW-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

[hw/rtl/game_pad_serial_port_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// game_pad_serial_port_unit
// Four-pad controller port with latched frames and serial shift readout.
// ---------------------------------------------------------------------------
// Usage:
//   in_i carries command transactions (frame sample, vsync latch, bus write,
//   bus read). out_o carries one read_data transaction per bus read; other
//   commands produce nothing on out_o.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while
//   the unit is idle; registers take effect on the next command.
//   Timing: a command is taken into an input register at accept and is
//   executed from there; a read writes its data into the output register,
//   which drives out_o.
//   Throughput: one command per cycle unless a read is held by an out_o
//   stall, set by the single execute stage between the input and output registers.
//   When out_o stalls with a result pending, a read waiting in the input
//   register holds, and in_i stays ready only while that register is free.
//   Non-read commands still execute under a stall.
//   Reset (rst_ni low, asynchronous) clears configuration, pad bytes, mic
//   bits, turbo phases, strobe state and shift registers, and empties both
//   the input and output registers.
// ---------------------------------------------------------------------------
module game_pad_serial_port_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gpsp_in_if.sink                       in_i,
  gpsp_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [gpsp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gpsp_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import gpsp_pkg::*;

  cfg_t       cfg_q;
  in_item_t   s1_q;
  logic       s1_valid_q;
  logic       out_valid_q;
  logic [RdataW-1:0] rdata_q;

  pad_bytes_t frame_q, latched_q, frame_d;
  logic       frame_mic_q, latched_mic_q, strobe_q;
  logic [7:0][PhaseW-1:0]       phase_q, phase_d;
  logic [1:0][MainW-1:0]        main_q, load_main;
  logic [1:0][ByteW-1:0]        extra_q, load_extra;

  logic s1_is_read, s1_fire, in_fire, out_fire, do_load;
  logic [NumPads-1:0][BtnW-1:0] raw;
  logic [RdataW-1:0] rdata_d;

  assign out_fire   = out_valid_q && out_o.ready;
  assign s1_is_read = (s1_q.cmd == CmdRead);
  assign s1_fire    = s1_valid_q && (!s1_is_read || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire    = in_i.valid && in_i.ready;

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = rdata_q;

  assign raw = {s1_q.buttons_pad4, s1_q.buttons_pad3, s1_q.buttons_pad2,
                s1_q.buttons_pad1};

  for (genvar g = 0; g < NumPads; g++) begin : g_pad
    gpsp_pad u_pad (
      .buttons_i (raw[g]),
      .speeds_i  (cfg_q.turbo_speeds[g*4 +: 4]),
      .phase_i   (phase_q[g*2 +: 2]),
      .byte_o    (frame_d[g]),
      .phase_o   (phase_d[g*2 +: 2])
    );
  end

  gpsp_load u_load (
    .cfg_i     (cfg_q),
    .latched_i (latched_q),
    .main_o    (load_main),
    .extra_o   (load_extra)
  );

  // falling strobe write on the first port reloads the shifters
  assign do_load = s1_fire && (s1_q.cmd == CmdWrite) && !s1_q.port_sel
                   && !s1_q.strobe_bit && strobe_q;

  always_comb begin
    rdata_d    = {1'b0, extra_q[s1_q.port_sel][0], main_q[s1_q.port_sel][0]};
    rdata_d[2] = !s1_q.port_sel && !cfg_q.arcade_mode && latched_mic_q;
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgArcadeMode:  cfg_q.arcade_mode  <= cfg_wdata_i[0];
        CfgSwapType:    cfg_q.swap_type    <= cfg_wdata_i[2:0];
        CfgFourPlayer:  cfg_q.four_player  <= cfg_wdata_i[0];
        CfgTurboSpeeds: cfg_q.turbo_speeds <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= '{cmd: in_i.cmd, port_sel: in_i.port_sel, strobe_bit: in_i.strobe_bit,
                buttons_pad1: in_i.buttons_pad1, buttons_pad2: in_i.buttons_pad2,
                buttons_pad3: in_i.buttons_pad3, buttons_pad4: in_i.buttons_pad4,
                mic_button: in_i.mic_button};
    end
  end

  // execute stage: port state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q       <= '0;
      latched_q     <= '0;
      frame_mic_q   <= 1'b0;
      latched_mic_q <= 1'b0;
      strobe_q      <= 1'b0;
      phase_q       <= '0;
      main_q        <= '0;
      extra_q       <= '0;
      out_valid_q   <= 1'b0;
      rdata_q       <= '0;
    end else begin
      // a new read result replaces the one leaving in the same cycle
      if (out_fire || (s1_fire && s1_is_read)) begin
        out_valid_q <= s1_fire && s1_is_read;
      end
      if (s1_fire) begin
        case (s1_q.cmd)
          CmdFrame: begin
            frame_q     <= frame_d;
            phase_q     <= phase_d;
            frame_mic_q <= s1_q.mic_button;
          end
          CmdVsync: begin
            latched_q     <= frame_q;
            latched_mic_q <= frame_mic_q;
          end
          CmdWrite: begin
            if (!s1_q.port_sel) begin
              if (s1_q.strobe_bit) begin
                strobe_q <= 1'b1;
              end else if (strobe_q) begin
                strobe_q <= 1'b0;
              end
            end
            if (do_load) begin
              main_q  <= load_main;
              extra_q <= load_extra;
              if (cfg_q.arcade_mode) begin
                frame_mic_q <= 1'b0;
              end
            end
          end
          CmdRead: begin
            main_q[s1_q.port_sel]  <= main_q[s1_q.port_sel] >> 1;
            extra_q[s1_q.port_sel] <= extra_q[s1_q.port_sel] >> 1;
            rdata_q     <= rdata_d;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

[hw/rtl/gpsp_pad.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gpsp_pad
// Builds one pad byte from raw buttons and advances its two turbo phases.
// ---------------------------------------------------------------------------
module gpsp_pad (
  input  logic [gpsp_pkg::BtnW-1:0]         buttons_i,
  input  logic [3:0]                        speeds_i,
  input  logic [1:0][gpsp_pkg::PhaseW-1:0]  phase_i,
  output logic [gpsp_pkg::ByteW-1:0]        byte_o,
  output logic [1:0][gpsp_pkg::PhaseW-1:0]  phase_o
);
  import gpsp_pkg::*;

  // returns {on, next_phase}
  function automatic logic [PhaseW:0] turbo_step(input logic [PhaseW-1:0] ph,
                                                 input logic [1:0] spd);
    logic [PhaseW-1:0] p;
    logic [PhaseW-1:0] nxt;
    p   = (ph >= SpeedLen[spd]) ? '0 : ph;
    nxt = p + PhaseW'(1);
    return {(p < SpeedOn[spd]), nxt};
  endfunction

  logic [3:0]        dir;
  logic [PhaseW:0]   step_a;
  logic [PhaseW:0]   step_b;
  logic              hold_a;
  logic              hold_b;

  always_comb begin
    dir = buttons_i[3:0];
    // left and right together cancel
    if (dir[3:2] == 2'b11) begin
      dir[3:2] = 2'b00;
    end
    hold_a = buttons_i[6];
    hold_b = buttons_i[7];
    step_a = turbo_step(phase_i[0], speeds_i[1:0]);
    step_b = turbo_step(phase_i[1], speeds_i[3:2]);

    byte_o = {dir, buttons_i[9], buttons_i[8],
              hold_b ? step_b[PhaseW] : buttons_i[5],
              hold_a ? step_a[PhaseW] : buttons_i[4]};
    phase_o[0] = hold_a ? step_a[PhaseW-1:0] : '0;
    phase_o[1] = hold_b ? step_b[PhaseW-1:0] : '0;
  end

endmodule

[hw/rtl/gpsp_load.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gpsp_load
// Computes shift register load values from the latched pad bytes.
// ---------------------------------------------------------------------------
module gpsp_load (
  input  gpsp_pkg::cfg_t                    cfg_i,
  input  gpsp_pkg::pad_bytes_t              latched_i,
  output logic [1:0][gpsp_pkg::MainW-1:0]   main_o,
  output logic [1:0][gpsp_pkg::ByteW-1:0]   extra_o
);
  import gpsp_pkg::*;

  logic [ByteW-1:0] p1, p2, s1, s2, a, b;

  always_comb begin
    p1 = latched_i[0] & PadMask;
    p2 = latched_i[1] & PadMask;
    // start button moved to bit 2
    s1 = {5'd0, latched_i[0][3], 2'd0};
    s2 = {5'd0, latched_i[1][3], 2'd0};
    case (cfg_i.swap_type)
      SwapNone:       begin a = p1 | s1; b = p2 | s2; end
      SwapPads:       begin a = p2 | s1; b = p1 | s2; end
      SwapMergeOwn:   begin a = p1 | s1 | (s2 << 1); b = p2; end
      SwapMergeCross: begin a = p2 | s1 | (s2 << 1); b = p1; end
      SwapNoneForce:  begin a = p1 | s1 | CoinBit; b = p2 | s2 | CoinBit; end
      SwapPadsForce:  begin a = p2 | s1 | CoinBit; b = p1 | s2 | CoinBit; end
      SwapSelect: begin
        a = p1 | s1 | {4'd0, latched_i[0][2], 3'd0};
        b = p2 | s2 | {4'd0, latched_i[1][2], 3'd0};
      end
      default:        begin a = '0; b = '0; end
    endcase

    if (cfg_i.arcade_mode) begin
      main_o[0] = MainW'(a);
      main_o[1] = MainW'(b);
    end else if (cfg_i.four_player) begin
      main_o[0] = {4'd0, latched_i[2], latched_i[0]} | SigPort0;
      main_o[1] = {4'd0, latched_i[3], latched_i[1]} | SigPort1;
    end else begin
      main_o[0] = MainW'(latched_i[0]);
      main_o[1] = MainW'(latched_i[1]);
    end
    extra_o[0] = latched_i[2];
    extra_o[1] = latched_i[3];
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for game_pad_serial_port_unit.
// Frame samples, vsync latches, strobe writes and serial reads are pushed
// through the command channel under several port settings. A behavioral
// predictor tracks pad bytes, turbo phases and shift registers, and each
// read transaction on the result channel is compared against it in order.
// ---------------------------------------------------------------------------
module tb;
  import gpsp_pkg::*;

  class serial_read_predictor;
    cfg_t              cfg;
    logic [ByteW-1:0]  cur_pad[NumPads];
    logic              cur_mic;
    logic [ByteW-1:0]  vs_pad[NumPads];
    logic              vs_mic;
    logic [PhaseW-1:0] turbo_ph[2*NumPads];
    logic              strobe_armed;
    logic [MainW-1:0]  ser_main[2];
    logic [ByteW-1:0]  ser_extra[2];
    logic [RdataW-1:0] expected_reads[$];

    function new();
      cfg = '0;
      cur_mic = 1'b0;
      vs_mic = 1'b0;
      strobe_armed = 1'b0;
      foreach (cur_pad[i]) begin
        cur_pad[i] = '0;
        vs_pad[i] = '0;
      end
      foreach (turbo_ph[i]) turbo_ph[i] = '0;
      foreach (ser_main[i]) begin
        ser_main[i] = '0;
        ser_extra[i] = '0;
      end
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CfgArcadeMode:  cfg.arcade_mode = val[0];
        CfgSwapType:    cfg.swap_type = val[2:0];
        CfgFourPlayer:  cfg.four_player = val[0];
        CfgTurboSpeeds: cfg.turbo_speeds = val;
        default: ;
      endcase
    endfunction

    // btn 0 gates A, btn 1 gates B; b[8+btn] is the matching turbo button
    function logic [9:0] turbo_gate(logic [9:0] b, int unsigned pad, int unsigned btn);
      int unsigned       idx;
      logic [1:0]        spd;
      logic [PhaseW-1:0] plen;
      logic [PhaseW-1:0] pon;
      idx = pad * 2 + btn;
      if (b[8 + btn]) begin
        spd = cfg.turbo_speeds[pad * 4 + btn * 2 +: 2];
        case (spd)
          2'd0: begin plen = 3'd6; pon = 3'd3; end
          2'd1: begin plen = 3'd4; pon = 3'd2; end
          2'd2: begin plen = 3'd3; pon = 3'd2; end
          default: begin plen = 3'd2; pon = 3'd1; end
        endcase
        if (turbo_ph[idx] >= plen) turbo_ph[idx] = '0;
        b[btn] = (turbo_ph[idx] < pon);
        turbo_ph[idx] = turbo_ph[idx] + 3'd1;
      end else begin
        turbo_ph[idx] = '0;
      end
      return b;
    endfunction

    function logic [ByteW-1:0] encode_pad(logic [BtnW-1:0] raw, int unsigned pad);
      logic [9:0] b;
      b = '0;
      b[7:4] = raw[3:0];
      if (b[7:6] == 2'b11) b[7:6] = 2'b00;  // opposite directions cancel
      b[1:0] = raw[5:4];
      b[9:8] = raw[7:6];
      b[3:2] = raw[9:8];
      b = turbo_gate(b, pad, 0);
      b = turbo_gate(b, pad, 1);
      return b[7:0];
    endfunction

    function void load_serial_regs();
      logic [ByteW-1:0] p1, p2;
      logic             s1, s2;
      logic [MainW-1:0] a, b;
      if (cfg.arcade_mode) begin
        p1 = vs_pad[0] & PadMask;
        p2 = vs_pad[1] & PadMask;
        s1 = vs_pad[0][3];
        s2 = vs_pad[1][3];
        a = '0;
        b = '0;
        case (cfg.swap_type)
          SwapNone: begin
            a = {12'd0, p1}; a[2] = s1; b = {12'd0, p2}; b[2] = s2;
          end
          SwapPads: begin
            a = {12'd0, p2}; a[2] = s1; b = {12'd0, p1}; b[2] = s2;
          end
          SwapMergeOwn: begin
            a = {12'd0, p1}; a[2] = s1; a[3] = s2; b = {12'd0, p2};
          end
          SwapMergeCross: begin
            a = {12'd0, p2}; a[2] = s1; a[3] = s2; b = {12'd0, p1};
          end
          SwapNoneForce: begin
            a = {12'd0, p1}; a[2] = s1; a[3] = 1'b1;
            b = {12'd0, p2}; b[2] = s2; b[3] = 1'b1;
          end
          SwapPadsForce: begin
            a = {12'd0, p2}; a[2] = s1; a[3] = 1'b1;
            b = {12'd0, p1}; b[2] = s2; b[3] = 1'b1;
          end
          SwapSelect: begin
            a = {12'd0, p1}; a[2] = s1; a[3] = vs_pad[0][2];
            b = {12'd0, p2}; b[2] = s2; b[3] = vs_pad[1][2];
          end
          default: ;  // all-zero mode
        endcase
        ser_main[0] = a;
        ser_main[1] = b;
        cur_mic = 1'b0;
      end else if (cfg.four_player) begin
        ser_main[0] = {4'd0, vs_pad[2], vs_pad[0]} | SigPort0;
        ser_main[1] = {4'd0, vs_pad[3], vs_pad[1]} | SigPort1;
      end else begin
        ser_main[0] = {12'd0, vs_pad[0]};
        ser_main[1] = {12'd0, vs_pad[1]};
      end
      ser_extra[0] = vs_pad[2];
      ser_extra[1] = vs_pad[3];
    endfunction

    function void note_command(in_item_t it);
      int unsigned       port;
      logic [RdataW-1:0] d;
      port = it.port_sel;
      case (it.cmd)
        CmdFrame: begin
          cur_pad[0] = encode_pad(it.buttons_pad1, 0);
          cur_pad[1] = encode_pad(it.buttons_pad2, 1);
          cur_pad[2] = encode_pad(it.buttons_pad3, 2);
          cur_pad[3] = encode_pad(it.buttons_pad4, 3);
          cur_mic = it.mic_button;
        end
        CmdVsync: begin
          vs_pad = cur_pad;
          vs_mic = cur_mic;
        end
        CmdWrite: begin
          if (port == 0) begin
            if (it.strobe_bit) begin
              strobe_armed = 1'b1;
            end else if (strobe_armed) begin
              strobe_armed = 1'b0;
              load_serial_regs();
            end
          end
        end
        default: begin
          d = {1'b0, ser_extra[port][0], ser_main[port][0]};
          ser_main[port] = ser_main[port] >> 1;
          ser_extra[port] = ser_extra[port] >> 1;
          if (port == 0 && !cfg.arcade_mode && vs_mic) d[2] = 1'b1;
          expected_reads.push_back(d);
        end
      endcase
    endfunction

    function bit check_read(logic [RdataW-1:0] got, output string msg);
      logic [RdataW-1:0] want;
      msg = "";
      if (expected_reads.size() == 0) begin
        msg = $sformatf("read_data %0d arrived with no read outstanding", got);
        return 1'b0;
      end
      want = expected_reads.pop_front();
      if (got !== want) begin
        msg = $sformatf("read_data got %03b, want %03b", got, want);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function int unsigned pending();
      return expected_reads.size();
    endfunction
  endclass

  localparam int unsigned IdleLimit     = 1000;
  localparam int unsigned ItemsPerPhase = 65;
  localparam int unsigned NumPhases     = 14;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  gpsp_in_if  in_ch ();
  gpsp_out_if out_ch ();

  game_pad_serial_port_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  serial_read_predictor pred = new();

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;
  logic [BtnW-1:0] held_btn[NumPads];
  string       check_msg;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int unsigned draw_gap();
    return quiet ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic in_item_t rand_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t cmd_item(logic [CmdW-1:0] cmd, logic port, logic stb);
    in_item_t it;
    it = rand_item();
    it.cmd = cmd;
    it.port_sel = port;
    it.strobe_bit = stb;
    return it;
  endfunction

  function automatic in_item_t frame_of(logic [BtnW-1:0] b1, logic [BtnW-1:0] b2,
                                        logic [BtnW-1:0] b3, logic [BtnW-1:0] b4,
                                        logic mic);
    in_item_t it;
    it = cmd_item(CmdFrame, 1'b0, 1'b0);
    it.buttons_pad1 = b1;
    it.buttons_pad2 = b2;
    it.buttons_pad3 = b3;
    it.buttons_pad4 = b4;
    it.mic_button = mic;
    return it;
  endfunction

  // pads mostly keep their buttons across frames so turbo phases get to cycle
  function automatic in_item_t frame_item();
    for (int i = 0; i < NumPads; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        held_btn[i] = 10'($urandom_range(0, 1023));
        if ($urandom_range(0, 1)) held_btn[i][7:6] = 2'b11;
      end
    end
    return frame_of(held_btn[0], held_btn[1], held_btn[2], held_btn[3],
                    1'($urandom_range(0, 1)));
  endfunction

  // starts after an accept edge, returns on the edge that takes the transaction
  task automatic send(in_item_t it);
    int unsigned gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.cmd = it.cmd;
    in_ch.port_sel = it.port_sel;
    in_ch.strobe_bit = it.strobe_bit;
    in_ch.buttons_pad1 = it.buttons_pad1;
    in_ch.buttons_pad2 = it.buttons_pad2;
    in_ch.buttons_pad3 = it.buttons_pad3;
    in_ch.buttons_pad4 = it.buttons_pad4;
    in_ch.mic_button = it.mic_button;
    in_ch.valid = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  // wait for every read to come back plus the execute stage to empty
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (pred.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    pred.set_reg(idx, val);
  endtask

  task automatic set_port_mode(logic arcade, logic [2:0] swap, logic four,
                               logic [CfgDataW-1:0] speeds);
    write_reg(CfgArcadeMode, {15'd0, arcade});
    write_reg(CfgSwapType, {13'd0, swap});
    write_reg(CfgFourPlayer, {15'd0, four});
    write_reg(CfgTurboSpeeds, speeds);
  endtask

  task automatic run_sequence();
    int unsigned shape;
    quiet = ($urandom_range(0, 3) == 0);
    repeat ($urandom_range(1, 4)) send(frame_item());
    shape = $urandom_range(0, 9);
    if (shape != 0) send(cmd_item(CmdVsync, 1'b0, 1'b0));
    case (shape)
      1: ;  // no strobe at all, shift registers keep draining
      2: begin
        send(cmd_item(CmdWrite, 1'b1, 1'b1));
        send(cmd_item(CmdWrite, 1'b0, 1'b0));
      end
      3: begin
        send(cmd_item(CmdWrite, 1'b0, 1'b1));
        send(cmd_item(CmdWrite, 1'b0, 1'b0));
        send(cmd_item(CmdWrite, 1'b0, 1'b0));
      end
      default: begin
        send(cmd_item(CmdWrite, 1'b0, 1'b1));
        send(cmd_item(CmdWrite, 1'b0, 1'b0));
      end
    endcase
    repeat ($urandom_range(1, 24)) begin
      send(cmd_item(CmdRead, 1'($urandom_range(0, 1)), 1'($urandom)));
    end
    repeat ($urandom_range(0, 2)) send(rand_item());
  endtask

  // result side: random stall before each transaction
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      @(negedge clk_i);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      pred.note_command('{cmd: in_ch.cmd, port_sel: in_ch.port_sel,
                          strobe_bit: in_ch.strobe_bit,
                          buttons_pad1: in_ch.buttons_pad1,
                          buttons_pad2: in_ch.buttons_pad2,
                          buttons_pad3: in_ch.buttons_pad3,
                          buttons_pad4: in_ch.buttons_pad4,
                          mic_button: in_ch.mic_button});
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (!pred.check_read(out_ch.read_data, check_msg)) report_mismatch(check_msg);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_start;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CmdFrame;
    in_ch.port_sel = 1'b0;
    in_ch.strobe_bit = 1'b0;
    in_ch.buttons_pad1 = '0;
    in_ch.buttons_pad2 = '0;
    in_ch.buttons_pad3 = '0;
    in_ch.buttons_pad4 = '0;
    in_ch.mic_button = 1'b0;
    foreach (held_btn[i]) held_btn[i] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: all buttons, opposite directions, turbo, strobe corner cases
    set_port_mode(1'b0, 3'd0, 1'b0, 16'h0000);
    send(frame_of(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 1'b1));
    send(frame_of(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 1'b1));
    send(cmd_item(CmdVsync, 1'b0, 1'b0));
    send(cmd_item(CmdWrite, 1'b0, 1'b1));
    send(cmd_item(CmdWrite, 1'b0, 1'b0));
    repeat (3) send(cmd_item(CmdRead, 1'b0, 1'b0));
    repeat (2) send(cmd_item(CmdRead, 1'b1, 1'b1));
    send(cmd_item(CmdWrite, 1'b1, 1'b1));
    send(cmd_item(CmdWrite, 1'b0, 1'b0));  // no rise before: must not reload
    send(cmd_item(CmdRead, 1'b0, 1'b0));
    send(frame_of(10'h00C, 10'h003, 10'h0C0, 10'h300, 1'b0));
    send(cmd_item(CmdVsync, 1'b0, 1'b0));
    send(cmd_item(CmdWrite, 1'b0, 1'b1));
    send(cmd_item(CmdWrite, 1'b0, 1'b0));
    send(cmd_item(CmdRead, 1'b0, 1'b0));
    send(cmd_item(CmdRead, 1'b1, 1'b0));
    send(frame_of(10'h000, 10'h000, 10'h000, 10'h000, 1'b0));
    send(cmd_item(CmdVsync, 1'b0, 1'b0));
    send(cmd_item(CmdRead, 1'b0, 1'b0));

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      if (ph == 0) begin
        set_port_mode(1'b0, 3'd7, 1'b0, 16'h0000);
      end else if (ph == 1) begin
        set_port_mode(1'b0, 3'd0, 1'b1, 16'hFFFF);
      end else if (ph < 10) begin
        // arcade cabinet, every swap mode including all-zero
        set_port_mode(1'b1, 3'(ph - 2), 1'($urandom_range(0, 1)),
                      16'($urandom_range(0, 65535)));
      end else begin
        set_port_mode(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
      end
      phase_start = items_sent;
      while (items_sent - phase_start < ItemsPerPhase) run_sequence();
    end
    drain();

    if (mismatches == 0 && pred.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
